@@ sv/mlfq_pkg.sv @@
// Shared types and constants for the MLFQ CPU scheduler.
package mlfq_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int LEVELS     = 3;
    localparam int MLFQ_SLICE = 2;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARRIVE = 2'd1,
        OP_IORET  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_FIFO = 2'd0,
        MODE_RR   = 2'd1,
        MODE_MLFQ = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_QUANT = 2'd1,
        REG_BOOST = 2'd2,
        REG_NCPU  = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READY,
        ST_BOOST_CHK,
        ST_BOOST_POP,
        ST_BOOST_PUSH,
        ST_BOOST_CPU,
        ST_PICK,
        ST_PICK_LOAD,
        ST_DEC
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready_item;   // apply a ready item
        logic boost_div;    // start boost check (load divider)
        logic boost_pop;    // issue read of head of boost level
        logic boost_push;   // push read pid to level 0
        logic boost_cpu;    // clear levels of running pids
        logic pick_read;    // issue read for dispatch on current cpu
        logic pick_load;    // load CPU from read data
        logic advance;      // now++
        logic dec_cpu;      // decrement current cpu burst
        logic emit;         // present result of current cpu
        logic next_cpu;     // step cpu pointer
        logic clr_cpu;      // clear cpu pointer
        logic next_lv;      // step boost level
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic boost_due;
        logic lv_nonempty;  // boost level has entries
        logic lv_last;      // boost level is the last one
        logic pick_ok;      // current cpu idle, in range and queue nonempty
        logic seg_end;      // current cpu segment ends
        logic cpu_last;     // current cpu pointer is 1
        logic out_free;     // output register empty or being taken
    } status_t;

endpackage

@@ sv/mlfq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module mlfq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/mlfq_div.sv @@
// Iterative restoring remainder unit: 32-bit dividend by 16-bit divisor.
module mlfq_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic        rem_zero
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = !busy_reg && !start;
    assign rem_zero = (rem_reg == '0);
endmodule

@@ sv/mlfq_ctrl.sv @@
// Controller state machine for the MLFQ CPU scheduler.
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  opcode_t op,
    input  status_t st,
    output logic    in_ready,
    output cmd_t    cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_ARRIVE || op == OP_IORET)
                    begin
                        state_next = ST_READY;
                    end
                    else if (op == OP_TICK)
                    begin
                        cmd.boost_div = 1'b1;
                        state_next    = ST_BOOST_CHK;
                    end
                end
            end
            ST_READY:
            begin
                cmd.ready_item = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_BOOST_CHK:
            begin
                if (st.div_done)
                begin
                    cmd.clr_cpu = 1'b1;
                    state_next  = st.boost_due ? ST_BOOST_POP : ST_PICK;
                end
            end
            ST_BOOST_POP:
            begin
                if (st.lv_nonempty)
                begin
                    cmd.boost_pop = 1'b1;
                    state_next    = ST_BOOST_PUSH;
                end
                else if (st.lv_last)
                begin
                    state_next = ST_BOOST_CPU;
                end
                else
                begin
                    cmd.next_lv = 1'b1;
                end
            end
            ST_BOOST_PUSH:
            begin
                cmd.boost_push = 1'b1;
                state_next     = ST_BOOST_POP;
            end
            ST_BOOST_CPU:
            begin
                cmd.boost_cpu = 1'b1;
                state_next    = ST_PICK;
            end
            ST_PICK:
            begin
                if (st.pick_ok)
                begin
                    cmd.pick_read = 1'b1;
                    state_next    = ST_PICK_LOAD;
                end
                else if (st.cpu_last)
                begin
                    cmd.advance = 1'b1;
                    cmd.clr_cpu = 1'b1;
                    state_next  = ST_DEC;
                end
                else
                begin
                    cmd.next_cpu = 1'b1;
                end
            end
            ST_PICK_LOAD:
            begin
                cmd.pick_load = 1'b1;
                if (st.cpu_last)
                begin
                    cmd.advance = 1'b1;
                    cmd.clr_cpu = 1'b1;
                    state_next  = ST_DEC;
                end
                else
                begin
                    cmd.next_cpu = 1'b1;
                    state_next   = ST_PICK;
                end
            end
            // Step each CPU; an ending segment waits for a free output register
            ST_DEC:
            begin
                if (!st.seg_end || st.out_free)
                begin
                    cmd.emit    = st.seg_end;
                    cmd.dec_cpu = 1'b1;
                    if (st.cpu_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_cpu = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ sv/mlfq_dp.sv @@
// Datapath for the MLFQ CPU scheduler: queues, process table, CPUs, output register.
module mlfq_dp
    import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic        in_fire,
    input  logic [1:0]  in_op,
    input  logic [3:0]  in_pid,
    input  logic [15:0] in_len,
    input  logic        cfg_fire,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  seg_pid,
    output logic [7:0]  burst_number,
    output logic        cpu_id,
    output logic [31:0] start_tick,
    output logic [31:0] end_tick,
    output logic        reason,
    output logic        last
);
    localparam int PW = $clog2(MAX_PROCS);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int QD = LEVELS * MAX_PROCS;
    localparam int AW = $clog2(QD);
    localparam logic [CW-1:0] FULL = CW'(MAX_PROCS);
    localparam logic [LW-1:0] LV_TOP = LW'(LEVELS - 1);

    // configuration
    mode_t       mode_reg;
    logic [15:0] quant_reg, boost_reg;
    logic [1:0]  ncpu_reg;

    // queues
    logic [PW-1:0] head_reg [LEVELS];
    logic [PW-1:0] tail_reg [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];

    // process table
    logic [LW-1:0] plevel_reg [MAX_PROCS];
    logic [15:0]   prem_reg [MAX_PROCS];
    logic [7:0]    pburst_reg [MAX_PROCS];

    // CPUs
    logic          busy_reg [2];
    logic [PW-1:0] cpid_reg [2];
    logic [15:0]   slice_reg [2];
    logic [31:0]   cstart_reg [2];
    logic [31:0]   now_reg;

    // walk pointers and latched input
    logic          cpu_reg;
    logic [LW-1:0] blv_reg;
    logic [1:0]    op_reg;
    logic [PW-1:0] pid_reg;
    logic [15:0]   len_reg;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [PW-1:0] ram_wdata, ram_rdata;

    logic div_done, rem_zero;

    mlfq_ram #(.WIDTH(PW), .DEPTH(QD)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mlfq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.boost_div),
        .dividend (now_reg),
        .divisor  (boost_reg),
        .done     (div_done),
        .rem_zero (rem_zero)
    );

    function automatic logic [AW-1:0] slot_addr(logic [LW-1:0] lv, logic [PW-1:0] idx);
        return AW'(lv * MAX_PROCS) + AW'(idx);
    endfunction

    function automatic logic [PW-1:0] inc_ptr(logic [PW-1:0] p);
        return (p == PW'(MAX_PROCS - 1)) ? '0 : p + PW'(1);
    endfunction

    // derived selects
    logic          ncpu2;
    logic          cpu_ok;
    logic          any_q;
    logic [LW-1:0] pick_lv;
    logic [LW-1:0] rdy_lv;
    logic          rdy_ok;
    logic [PW-1:0] cur_pid;
    logic [15:0]   rem_dec;
    logic [15:0]   rem_cpu1;
    logic          seg_fin, seg_pre;
    logic [LW-1:0] pre_lv;
    logic [LW-1:0] pre_enq;

    always_comb
    begin
        ncpu2   = ncpu_reg[1];
        cpu_ok  = (cpu_reg == 1'b0) || ncpu2;
        any_q   = 1'b0;
        pick_lv = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if ((l == 0 || mode_reg == MODE_MLFQ) && count_reg[l] != '0)
            begin
                any_q   = 1'b1;
                pick_lv = LW'(l);
            end
        end
        rdy_lv = (op_reg == OP_IORET && mode_reg == MODE_MLFQ) ? plevel_reg[pid_reg] : '0;
        rdy_ok = (count_reg[rdy_lv] < FULL);
        cur_pid = cpid_reg[cpu_reg];
        rem_dec = prem_reg[cur_pid] - 16'd1;
        // CPU 1 steps after CPU 0, so a shared pid loses two ticks
        rem_cpu1 = prem_reg[cpid_reg[1]] -
                   ((cpid_reg[1] == cpid_reg[0]) ? 16'd2 : 16'd1);
        seg_fin = busy_reg[cpu_reg] && (rem_dec == '0);
        seg_pre = busy_reg[cpu_reg] && !seg_fin && (slice_reg[cpu_reg] == 16'd1);
        pre_lv  = (mode_reg == MODE_MLFQ && plevel_reg[cur_pid] != LV_TOP)
                  ? plevel_reg[cur_pid] + LW'(1) : plevel_reg[cur_pid];
        pre_enq = (mode_reg == MODE_MLFQ) ? pre_lv : '0;
    end

    // RAM addressing
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_addr(rdy_lv, tail_reg[rdy_lv]);
        ram_wdata = pid_reg;
        ram_raddr = slot_addr(pick_lv, head_reg[pick_lv]);
        if (cmd.ready_item)
        begin
            ram_we = rdy_ok;
        end
        else if (cmd.boost_push)
        begin
            ram_we    = (count_reg[0] < FULL);
            ram_waddr = slot_addr('0, tail_reg[0]);
            ram_wdata = ram_rdata;
        end
        else if (cmd.dec_cpu && seg_pre)
        begin
            ram_we    = (count_reg[pre_enq] < FULL);
            ram_waddr = slot_addr(pre_enq, tail_reg[pre_enq]);
            ram_wdata = cur_pid;
        end
        if (cmd.boost_pop)
        begin
            ram_raddr = slot_addr(blv_reg, head_reg[blv_reg]);
        end
    end

    // status
    always_comb
    begin
        st.div_done    = div_done;
        st.boost_due   = (mode_reg == MODE_MLFQ) && (boost_reg != '0) &&
                         (now_reg != '0) && rem_zero;
        st.lv_nonempty = (count_reg[blv_reg] != '0);
        st.lv_last     = (blv_reg == LV_TOP);
        st.pick_ok     = cpu_ok && !busy_reg[cpu_reg] && any_q;
        st.seg_end     = seg_fin || seg_pre;
        st.cpu_last    = cpu_reg;
        st.out_free    = !out_valid || out_ready;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FIFO;
            quant_reg <= 16'd10;
            boost_reg <= '0;
            ncpu_reg  <= 2'd1;
        end
        else if (cfg_fire)
        begin
            case (reg_index_t'(cfg_index))
                REG_MODE:  mode_reg  <= mode_t'(cfg_data[1:0]);
                REG_QUANT: quant_reg <= cfg_data;
                REG_BOOST: boost_reg <= cfg_data;
                REG_NCPU:  ncpu_reg  <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    // latched input item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= in_op;
            pid_reg <= PW'(in_pid);
            len_reg <= in_len;
        end
    end

    // process table, queues, CPUs and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            for (int p = 0; p < MAX_PROCS; p++)
            begin
                plevel_reg[p] <= '0;
                pburst_reg[p] <= '0;
            end
            for (int c = 0; c < 2; c++)
            begin
                busy_reg[c]   <= 1'b0;
                cpid_reg[c]   <= '0;
                slice_reg[c]  <= '0;
                cstart_reg[c] <= '0;
            end
            now_reg     <= '0;
            cpu_reg     <= 1'b0;
            blv_reg     <= LW'(1);
            out_valid   <= 1'b0;
        end
        else
        begin
            // ready item: enqueue with fresh burst
            if (cmd.ready_item && rdy_ok)
            begin
                if (op_reg == OP_ARRIVE)
                begin
                    plevel_reg[pid_reg] <= '0;
                    pburst_reg[pid_reg] <= 8'd1;
                end
                else if (pburst_reg[pid_reg] != 8'hFF)
                begin
                    pburst_reg[pid_reg] <= pburst_reg[pid_reg] + 8'd1;
                end
                prem_reg[pid_reg]   <= (len_reg == '0) ? 16'd1 : len_reg;
                tail_reg[rdy_lv]    <= inc_ptr(tail_reg[rdy_lv]);
                count_reg[rdy_lv]   <= count_reg[rdy_lv] + CW'(1);
            end

            if (cmd.clr_cpu)
            begin
                cpu_reg     <= 1'b0;
                blv_reg     <= LW'(1);
            end
            if (cmd.next_cpu)
            begin
                cpu_reg <= 1'b1;
            end
            if (cmd.next_lv)
            begin
                blv_reg <= blv_reg + LW'(1);
            end

            // boost walk
            if (cmd.boost_pop)
            begin
                head_reg[blv_reg]  <= inc_ptr(head_reg[blv_reg]);
                count_reg[blv_reg] <= count_reg[blv_reg] - CW'(1);
            end
            if (cmd.boost_push)
            begin
                plevel_reg[ram_rdata] <= '0;
                if (count_reg[0] < FULL)
                begin
                    tail_reg[0]  <= inc_ptr(tail_reg[0]);
                    count_reg[0] <= count_reg[0] + CW'(1);
                end
            end
            if (cmd.boost_cpu)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    if (busy_reg[c])
                    begin
                        plevel_reg[cpid_reg[c]] <= '0;
                    end
                end
            end

            // dispatch
            if (cmd.pick_read)
            begin
                head_reg[pick_lv]    <= inc_ptr(head_reg[pick_lv]);
                count_reg[pick_lv]   <= count_reg[pick_lv] - CW'(1);
            end
            if (cmd.pick_load)
            begin
                busy_reg[cpu_reg]   <= 1'b1;
                cpid_reg[cpu_reg]   <= ram_rdata;
                cstart_reg[cpu_reg] <= now_reg;
                case (mode_reg)
                    MODE_RR:   slice_reg[cpu_reg] <= quant_reg;
                    MODE_MLFQ: slice_reg[cpu_reg] <= 16'(MLFQ_SLICE);
                    default:   slice_reg[cpu_reg] <= '0;
                endcase
            end
            if (cmd.advance)
            begin
                now_reg <= now_reg + 32'd1;
            end

            // present an ended segment, or drop the one just taken
            if (cmd.emit)
            begin
                out_valid    <= 1'b1;
                seg_pid      <= 4'(cur_pid);
                burst_number <= pburst_reg[cur_pid];
                cpu_id       <= cpu_reg;
                start_tick   <= cstart_reg[cpu_reg];
                end_tick     <= now_reg;
                reason       <= seg_pre;
                last         <= cpu_reg || !(busy_reg[1] &&
                                ((rem_cpu1 == '0) || (slice_reg[1] == 16'd1)));
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end

            // burst decrement and segment end
            if (cmd.dec_cpu && busy_reg[cpu_reg])
            begin
                prem_reg[cur_pid] <= rem_dec;
                if (seg_fin || seg_pre)
                begin
                    busy_reg[cpu_reg]  <= 1'b0;
                    slice_reg[cpu_reg] <= '0;
                end
                else if (slice_reg[cpu_reg] != '0)
                begin
                    slice_reg[cpu_reg] <= slice_reg[cpu_reg] - 16'd1;
                end
                if (seg_pre)
                begin
                    plevel_reg[cur_pid] <= pre_lv;
                    if (count_reg[pre_enq] < FULL)
                    begin
                        tail_reg[pre_enq]  <= inc_ptr(tail_reg[pre_enq]);
                        count_reg[pre_enq] <= count_reg[pre_enq] + CW'(1);
                    end
                end
            end
        end
    end
endmodule

@@ sv/mlfq_round_robin_cpu_scheduler.sv @@
// Top level of the MLFQ / round robin / FIFO CPU scheduler.
//
// Channel   Dir  Handshake                Contents
// s_axis    in   s_tvalid / s_tready      tdata: opcode, pid, burst_length
// m_axis    out  m_tvalid / m_tready      tdata: segment record, tlast
// cfg       in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A ready item is latched, then enqueued. A tick first runs the boost-period
// remainder, then, if a boost is due, moves every entry of the lower levels
// to level 0, then dispatches on each CPU and steps the burst of each CPU. The
// remainder unit and the single queue RAM port set the pace of these steps.
// Reset clears all control state at once; no clearing pass is needed.
// A result waits in the output register; a later segment end stalls the tick.
module mlfq_round_robin_cpu_scheduler
    import mlfq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], pid[5:2], burst_length[21:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // seg_pid[3:0], burst_number[11:4], cpu_id[12],
                                   // start_time[44:13], end_time[76:45], reason[77]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    cmd_t        cmd;
    status_t     st;
    logic        in_fire;
    logic [3:0]  seg_pid;
    logic [7:0]  burst_number;
    logic        cpu_id;
    logic [31:0] start_tick, end_tick;
    logic        reason;

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .op       (opcode_t'(s_tdata[1:0])),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    mlfq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_fire      (in_fire),
        .in_op        (s_tdata[1:0]),
        .in_pid       (s_tdata[5:2]),
        .in_len       (s_tdata[21:6]),
        .cfg_fire     (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .seg_pid      (seg_pid),
        .burst_number (burst_number),
        .cpu_id       (cpu_id),
        .start_tick   (start_tick),
        .end_tick     (end_tick),
        .reason       (reason),
        .last         (m_tlast)
    );

    assign m_tdata = {2'b00, reason, end_tick, start_tick, cpu_id, burst_number, seg_pid};
endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the MLFQ / round robin / FIFO CPU scheduler.
module testbench;
    import mlfq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC       = 16;
    localparam int NLEVEL      = 3;
    localparam int SETTLE      = 400;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DUE_DEPTH   = 256;

    typedef struct {
        logic [3:0]  pid;
        logic [7:0]  burst_no;
        logic        cpu;
        logic [31:0] t_start;
        logic [31:0] t_end;
        logic        reason;
        logic        last;
    } segment_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow of the scheduler state
    logic [3:0]  slot_mem [NLEVEL][NPROC];
    logic [3:0]  q_head [NLEVEL];
    logic [3:0]  q_tail [NLEVEL];
    logic [4:0]  q_count [NLEVEL];
    logic [1:0]  proc_lvl [NPROC];
    logic [15:0] proc_left [NPROC];
    logic [7:0]  proc_bursts [NPROC];
    logic        cpu_on [2];
    logic [3:0]  cpu_proc [2];
    logic [15:0] cpu_slice [2];
    logic [31:0] cpu_t0 [2];
    logic [31:0] sched_now;

    // Shadow of the registers
    logic [1:0]  cur_mode;
    logic [15:0] cur_quantum;
    logic [15:0] cur_boost;
    logic [1:0]  cur_ncpu;

    // Expected segments, in order
    segment_t    due_mem [DUE_DEPTH];
    int          due_wr;
    int          due_rd;
    int          errors;
    int          cycles;
    bit          gaps_on;
    int          hold_cycles;

    mlfq_round_robin_cpu_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Queue helpers of the shadow
    function automatic void q_put(int lv, logic [3:0] p);
        if (q_count[lv] >= NPROC)
            return;
        slot_mem[lv][q_tail[lv]] = p;
        q_tail[lv]  = q_tail[lv] + 4'd1;
        q_count[lv] = q_count[lv] + 5'd1;
    endfunction

    function automatic logic [3:0] q_take(int lv);
        logic [3:0] p;
        p = slot_mem[lv][q_head[lv]];
        q_head[lv]  = q_head[lv] + 4'd1;
        q_count[lv] = q_count[lv] - 5'd1;
        return p;
    endfunction

    function automatic int home_level(logic [3:0] p);
        return (cur_mode == MODE_MLFQ) ? int'(proc_lvl[p]) : 0;
    endfunction

    // Work out the segments that one accepted item ends
    function automatic void schedule_item(logic [1:0] op, logic [3:0] pid, logic [15:0] len);
        int         lv;
        int         ncpu;
        int         top;
        int         n;
        logic [3:0] p;
        logic       why;
        segment_t   seg;
        segment_t   ended [2];
        n = 0;
        if (op == OP_ARRIVE || op == OP_IORET)
        begin
            lv = (op == OP_ARRIVE) ? 0 : home_level(pid);
            if (q_count[lv] >= NPROC)
                return;
            if (op == OP_ARRIVE)
            begin
                proc_lvl[pid]    = 2'd0;
                proc_bursts[pid] = 8'd0;
            end
            if (proc_bursts[pid] != 8'd255)
                proc_bursts[pid] = proc_bursts[pid] + 8'd1;
            proc_left[pid] = (len == 16'd0) ? 16'd1 : len;
            q_put(lv, pid);
            return;
        end
        if (op != OP_TICK)
            return;
        // Periodic boost
        if (cur_mode == MODE_MLFQ && cur_boost != 0 && sched_now != 0
                && sched_now % cur_boost == 0)
        begin
            for (lv = 1; lv < NLEVEL; lv++)
                while (q_count[lv] > 0)
                begin
                    p = q_take(lv);
                    proc_lvl[p] = 2'd0;
                    q_put(0, p);
                end
            for (int c = 0; c < 2; c++)
                if (cpu_on[c])
                    proc_lvl[cpu_proc[c]] = 2'd0;
        end
        // Dispatch to idle CPUs
        ncpu = (cur_ncpu >= 2) ? 2 : 1;
        top  = (cur_mode == MODE_MLFQ) ? NLEVEL : 1;
        for (int c = 0; c < ncpu; c++)
        begin
            if (cpu_on[c])
                continue;
            for (lv = 0; lv < top; lv++)
                if (q_count[lv] > 0)
                begin
                    cpu_on[c]   = 1'b1;
                    cpu_proc[c] = q_take(lv);
                    cpu_t0[c]   = sched_now;
                    if (cur_mode == MODE_RR)
                        cpu_slice[c] = cur_quantum;
                    else if (cur_mode == MODE_MLFQ)
                        cpu_slice[c] = 16'(MLFQ_SLICE);
                    else
                        cpu_slice[c] = 16'd0;
                    break;
                end
        end
        sched_now = sched_now + 32'd1;
        // Run one tick on every busy CPU
        for (int c = 0; c < 2; c++)
        begin
            if (!cpu_on[c])
                continue;
            p = cpu_proc[c];
            proc_left[p] = proc_left[p] - 16'd1;
            if (proc_left[p] == 16'd0)
                why = 1'b0;
            else if (cpu_slice[c] != 0)
            begin
                cpu_slice[c] = cpu_slice[c] - 16'd1;
                if (cpu_slice[c] != 0)
                    continue;
                why = 1'b1;
            end
            else
                continue;
            seg.pid      = p;
            seg.burst_no = proc_bursts[p];
            seg.cpu      = c[0];
            seg.t_start  = cpu_t0[c];
            seg.t_end    = sched_now;
            seg.reason   = why;
            seg.last     = 1'b0;
            ended[n]     = seg;
            n++;
            cpu_on[c]    = 1'b0;
            cpu_slice[c] = 16'd0;
            if (why)
            begin
                if (cur_mode == MODE_MLFQ && proc_lvl[p] < NLEVEL - 1)
                    proc_lvl[p] = proc_lvl[p] + 2'd1;
                q_put(home_level(p), p);
            end
        end
        if (n > 0)
            ended[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            due_mem[due_wr % DUE_DEPTH] = ended[i];
            due_wr++;
        end
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_wr == due_rd)
                report_mismatch("unexpected seg_pid", 32'(m_tdata[3:0]), 32'd0);
            else
            begin
                want = due_mem[due_rd % DUE_DEPTH];
                due_rd++;
                if (m_tdata[3:0] !== want.pid)
                    report_mismatch("seg_pid", m_tdata[3:0], want.pid);
                if (m_tdata[11:4] !== want.burst_no)
                    report_mismatch("burst_number", m_tdata[11:4], want.burst_no);
                if (m_tdata[12] !== want.cpu)
                    report_mismatch("cpu_id", m_tdata[12], want.cpu);
                if (m_tdata[44:13] !== want.t_start)
                    report_mismatch("start_time", m_tdata[44:13], want.t_start);
                if (m_tdata[76:45] !== want.t_end)
                    report_mismatch("end_time", m_tdata[76:45], want.t_end);
                if (m_tdata[77] !== want.reason)
                    report_mismatch("reason", m_tdata[77], want.reason);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // Receiver: random stalls and long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= !(gaps_on && $urandom_range(99) < 34);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one item; entered and left at a falling edge
    task automatic send_item(logic [1:0] op, logic [3:0] pid, logic [15:0] len);
        while (gaps_on && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, len, pid, op};
        do
            @(posedge clk);
        while (!s_tready);
        schedule_item(op, pid, len);
        @(negedge clk);
    endtask

    // Stop sending and wait until every segment has been taken and the block settles
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_wr != due_rd)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MODE:  cur_mode    = value[1:0];
            REG_QUANT: cur_quantum = value;
            REG_BOOST: cur_boost   = value;
            REG_NCPU:  cur_ncpu    = value[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_phase(logic [1:0] m, logic [15:0] q, logic [15:0] b, logic [1:0] n);
        drain();
        write_reg(REG_MODE, {14'd0, m});
        write_reg(REG_QUANT, q);
        write_reg(REG_BOOST, b);
        write_reg(REG_NCPU, {14'd0, n});
    endtask

    // Random item mix; bursts mostly short, occasionally full width when wide_bursts is set
    task automatic random_items(int count, bit wide_bursts);
        int          r;
        logic [15:0] len;
        for (int i = 0; i < count; i++)
        begin
            r   = $urandom_range(99);
            len = 16'($urandom_range(4));
            if (wide_bursts && $urandom_range(99) < 5)
                len = 16'($urandom);
            if (r < 58)
                send_item(OP_TICK, 4'($urandom), 16'($urandom));
            else if (r < 80)
                send_item(OP_ARRIVE, 4'($urandom), len);
            else if (r < 96)
                send_item(OP_IORET, 4'($urandom), len);
            else
                send_item(OP_NONE, 4'($urandom), 16'($urandom));
        end
    endtask

    // Reset defaults: FIFO, zero burst, unused opcode, return from I/O
    task automatic test_fifo_basics();
        send_item(OP_ARRIVE, 4'd0, 16'd1);
        send_item(OP_ARRIVE, 4'd15, 16'd0);
        send_item(OP_ARRIVE, 4'd7, 16'd3);
        send_item(OP_NONE, 4'd15, 16'hFFFF);
        repeat (6) send_item(OP_TICK, 4'd0, 16'd0);
        send_item(OP_IORET, 4'd15, 16'd2);
        send_item(OP_IORET, 4'd0, 16'd1);
        repeat (5) send_item(OP_TICK, 4'd15, 16'hFFFF);
    endtask

    // Seventeen ready items with no tick: the last finds the queue full
    task automatic test_queue_full();
        for (int i = 0; i < 17; i++)
            send_item(OP_ARRIVE, 4'(i), 16'd1);
        repeat (18) send_item(OP_TICK, 4'd0, 16'd0);
    endtask

    task automatic test_round_robin();
        set_phase(MODE_RR, 16'd1, 16'd0, 2'd2);
        send_item(OP_ARRIVE, 4'd1, 16'd3);
        send_item(OP_ARRIVE, 4'd2, 16'd2);
        send_item(OP_ARRIVE, 4'd3, 16'd1);
        repeat (6) send_item(OP_TICK, 4'd0, 16'd0);
        random_items(70, 1'b0);
        set_phase(MODE_RR, 16'hFFFF, 16'd0, 2'd3);
        random_items(50, 1'b0);
        // Zero slice: no preemption
        set_phase(MODE_RR, 16'd0, 16'd0, 2'd2);
        random_items(40, 1'b0);
    endtask

    task automatic test_mlfq();
        set_phase(MODE_MLFQ, 16'd3, 16'd0, 2'd1);
        random_items(90, 1'b0);
        // No idling on either side for a stretch
        gaps_on = 1'b0;
        set_phase(MODE_MLFQ, 16'd3, 16'd1, 2'd2);
        random_items(60, 1'b0);
        gaps_on = 1'b1;
    endtask

    // Receiver holds off while ticks keep coming, so the block backs up
    task automatic test_backpressure();
        set_phase(MODE_MLFQ, 16'd2, 16'd4, 2'd2);
        hold_cycles = 600;
        for (int i = 0; i < 8; i++)
            send_item(OP_ARRIVE, 4'(i), 16'd1);
        repeat (30) send_item(OP_TICK, 4'd0, 16'd0);
    endtask

    // Unused mode and CPU count below range
    task automatic test_odd_settings();
        set_phase(MODE_RSVD, 16'd5, 16'hFFFF, 2'd0);
        random_items(50, 1'b0);
    endtask

    // Long bursts last: they would block FIFO for good
    task automatic test_long_bursts();
        set_phase(MODE_MLFQ, 16'd7, 16'd5, 2'd2);
        send_item(OP_ARRIVE, 4'd15, 16'hFFFF);
        send_item(OP_ARRIVE, 4'd0, 16'hAAAA);
        send_item(OP_ARRIVE, 4'd5, 16'h5555);
        repeat (6) send_item(OP_TICK, 4'd0, 16'd0);
        random_items(60, 1'b1);
    endtask

    // Test sequence
    initial
    begin
        errors      = 0;
        cycles      = 0;
        due_wr      = 0;
        due_rd      = 0;
        gaps_on     = 1'b1;
        hold_cycles = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MODE;
        cfg_data    = '0;
        cur_mode    = MODE_FIFO;
        cur_quantum = 16'd10;
        cur_boost   = 16'd0;
        cur_ncpu    = 2'd1;
        sched_now   = '0;
        for (int lv = 0; lv < NLEVEL; lv++)
        begin
            q_head[lv]  = '0;
            q_tail[lv]  = '0;
            q_count[lv] = '0;
            for (int p = 0; p < NPROC; p++)
                slot_mem[lv][p] = '0;
        end
        for (int p = 0; p < NPROC; p++)
        begin
            proc_lvl[p]    = '0;
            proc_left[p]   = '0;
            proc_bursts[p] = '0;
        end
        for (int c = 0; c < 2; c++)
        begin
            cpu_on[c]    = 1'b0;
            cpu_proc[c]  = '0;
            cpu_slice[c] = '0;
            cpu_t0[c]    = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fifo_basics();
        test_queue_full();
        test_round_robin();
        test_mlfq();
        test_backpressure();
        test_odd_settings();
        test_long_bursts();
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/mlfq_pkg.sv
sv/mlfq_ram.sv
sv/mlfq_div.sv
sv/mlfq_ctrl.sv
sv/mlfq_dp.sv
sv/mlfq_round_robin_cpu_scheduler.sv
bench/testbench.sv
